/* hdl/iida_pkg.sv */
// ----------------------------------------------------------------------------
// iida_pkg
// Shared widths, operation and status codes, and the control bundle that the
// decoder hands to the storage cells of the indexed insert/delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 5;
    localparam int OP_W         = 2;
    localparam int ST_W         = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic             app_ok;
        logic             ins_ok;
        logic             del_ok;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } ctrl_t;

endpackage

/* hdl/iida_ctrl.sv */
// ----------------------------------------------------------------------------
// iida_ctrl
// Operation decoder: checks an operation against the entry count and the
// capacity limit, and produces the status, the new count and the cell controls.
// ----------------------------------------------------------------------------
module iida_ctrl #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
    input  logic [iida_pkg::OP_W-1:0]  operation,
    input  logic [iida_pkg::CNT_W-1:0] position,
    input  logic [iida_pkg::CNT_W-1:0] count,
    input  logic [iida_pkg::CNT_W-1:0] capacity,
    output iida_pkg::ctrl_t            ctrl,
    output logic [iida_pkg::ST_W-1:0]  status,
    output logic [iida_pkg::CNT_W-1:0] count_next
);

    localparam int CAP_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CAP_BITS > iida_pkg::CNT_W ? CAP_BITS : iida_pkg::CNT_W) + 1;

    logic [iida_pkg::CNT_W-1:0] limit;
    logic                       full;

    always_comb
    begin
        if (capacity == '0)
        begin
            limit = iida_pkg::CNT_W'(1);
        end
        else if (CMP_W'(capacity) > CMP_W'(CAPACITY))
        begin
            limit = iida_pkg::CNT_W'(CAPACITY);
        end
        else
        begin
            limit = capacity;
        end
    end

    assign full = (count >= limit);

    always_comb
    begin
        ctrl.app_ok = 1'b0;
        ctrl.ins_ok = 1'b0;
        ctrl.del_ok = 1'b0;
        ctrl.pos    = position;
        ctrl.count  = count;
        status      = iida_pkg::ST_OK;
        count_next  = count;
        unique case (operation)
            iida_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status = iida_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.app_ok = 1'b1;
                    count_next  = count + 1'b1;
                end
            end
            iida_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status = iida_pkg::ST_FULL;
                end
                else if (position > count)
                begin
                    status = iida_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.ins_ok = 1'b1;
                    count_next  = count + 1'b1;
                end
            end
            iida_pkg::OP_DELETE:
            begin
                if (position >= count)
                begin
                    status = iida_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.del_ok = 1'b1;
                    count_next  = count - 1'b1;
                end
            end
            iida_pkg::OP_UNUSED:
            begin
                status = iida_pkg::ST_RANGE;
            end
            default:
            begin
                status = iida_pkg::ST_RANGE;
            end
        endcase
    end

endmodule

/* hdl/iida_cell.sv */
// ----------------------------------------------------------------------------
// iida_cell
// One entry of the list. On each transfer it keeps its word, loads the new
// value, or takes the word of its left or right neighbor.
// ----------------------------------------------------------------------------
module iida_cell #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                        clk,
    input  logic                        step,
    input  iida_pkg::ctrl_t             ctrl,
    input  logic [iida_pkg::DATA_W-1:0] value,
    input  logic [iida_pkg::DATA_W-1:0] left_data,
    input  logic [iida_pkg::DATA_W-1:0] right_data,
    output logic [iida_pkg::DATA_W-1:0] data,
    output logic [iida_pkg::DATA_W-1:0] pick
);

    localparam int CAP_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CAP_BITS > iida_pkg::CNT_W ? CAP_BITS : iida_pkg::CNT_W) + 1;
    localparam logic [CMP_W-1:0] IDX  = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX1 = CMP_W'(INDEX + 1);

    logic [iida_pkg::DATA_W-1:0] data_reg;
    logic [iida_pkg::DATA_W-1:0] data_next;
    logic [CMP_W-1:0]            pos_ext;
    logic [CMP_W-1:0]            cnt_ext;
    logic                        load;
    logic                        up;
    logic                        down;

    assign pos_ext = CMP_W'(ctrl.pos);
    assign cnt_ext = CMP_W'(ctrl.count);

    assign load = (ctrl.app_ok && (IDX == cnt_ext)) || (ctrl.ins_ok && (IDX == pos_ext));
    assign up   = ctrl.ins_ok && (IDX > pos_ext) && (IDX <= cnt_ext);
    assign down = ctrl.del_ok && (IDX >= pos_ext) && (IDX1 < cnt_ext);

    always_comb
    begin
        if (load)
        begin
            data_next = value;
        end
        else if (up)
        begin
            data_next = left_data;
        end
        else if (down)
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;
    assign pick = (IDX == pos_ext) ? data_reg : '0;

endmodule

/* hdl/indexed_insert_delete_array.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// Packed list of signed 32-bit entries with append, insert at a position and
// delete at a position; every operation returns a status, the removed value
// and the new entry count.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, and on each transfer every cell either
// holds its word, loads the new value, or takes the word of a neighbor, so an
// insert or delete moves the whole tail in one transfer. The block shows its
// result in the cycle after the input transfer, from an output register. While a
// result waits there, the input is held off. A new operation can enter in the
// same cycle that the previous result is taken, so with a ready receiver one
// operation is accepted per clock cycle. The capacity register is written with
// cfg_wr_en and takes effect for the next operation; values of zero count as
// one and values above CAPACITY count as CAPACITY.
module indexed_insert_delete_array #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [iida_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [iida_pkg::OP_W-1:0]         operation,
    input  logic [iida_pkg::CNT_W-1:0]        position,
    input  logic signed [iida_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [iida_pkg::ST_W-1:0]         status,
    output logic signed [iida_pkg::DATA_W-1:0] removed_value,
    output logic [iida_pkg::CNT_W-1:0]        entry_count
);

    logic [iida_pkg::CNT_W-1:0]  capacity_reg;
    logic [iida_pkg::CNT_W-1:0]  count_reg;
    logic [iida_pkg::CNT_W-1:0]  count_next;
    logic                        out_valid_reg;
    logic [iida_pkg::ST_W-1:0]   status_reg;
    logic [iida_pkg::ST_W-1:0]   status_next;
    logic [iida_pkg::DATA_W-1:0] removed_reg;
    logic [iida_pkg::DATA_W-1:0] removed_next;
    logic [iida_pkg::CNT_W-1:0]  out_count_reg;
    logic                        in_xfer;
    iida_pkg::ctrl_t             ctrl;
    logic [iida_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic [iida_pkg::DATA_W-1:0] cell_pick [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    iida_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .operation  (operation),
        .position   (position),
        .count      (count_reg),
        .capacity   (capacity_reg),
        .ctrl       (ctrl),
        .status     (status_next),
        .count_next (count_next)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [iida_pkg::DATA_W-1:0] left_data;
        logic [iida_pkg::DATA_W-1:0] right_data;

        if (g == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_left
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_right
            assign right_data = cell_data[g+1];
        end

        iida_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .clk        (clk),
            .step       (in_xfer),
            .ctrl       (ctrl),
            .value      (value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g]),
            .pick       (cell_pick[g])
        );
    end

    always_comb
    begin
        removed_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed_next = removed_next | cell_pick[i];
        end
        if (!ctrl.del_ok)
        begin
            removed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= iida_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            out_count_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("entry count exceeds capacity");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && ctrl.del_ok |=> count_reg == $past(count_reg) - 1'b1)
        else $error("successful delete did not decrement the count");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (status_next != iida_pkg::ST_OK) |=> count_reg == $past(count_reg))
        else $error("rejected operation changed the count");

    a_out_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_xfer))
        else $error("result appeared without an input transfer");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_count_reg == count_reg)
        else $error("reported count differs from the stored count");

endmodule
